// ===== hdl/mwo_pkg.sv =====
// Shared types and constants for the mecanum wheel odometry unit.
package mwo_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_UPDATE     = 2'd0;
  localparam logic [1:0] REQ_INIT       = 2'd1;
  localparam logic [1:0] REQ_RESET_POSE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_RADIUS       = 2'd0;
  localparam logic [1:0] CFG_WHEEL_BASE_K = 2'd1;
  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd2;

  // Iteration counts of the shared divider
  localparam logic [5:0] TURN_STEPS = 6'd51;
  localparam logic [5:0] RATE_STEPS = 6'd33;
  localparam logic [5:0] MEAN_STEPS = 6'd40;

  // Microseconds per second
  localparam logic [19:0] ONE_MILLION = 20'd1000000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] front_left_angle;
    logic signed [31:0] front_right_angle;
    logic signed [31:0] back_left_angle;
    logic signed [31:0] back_right_angle;
    logic [39:0]        time_us;
  } mwo_in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [47:0] pose_x;
    logic signed [47:0] pose_y;
    logic signed [47:0] pose_heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_turn;
  } mwo_out_t;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_CHECK,
    CMD_WMUL,
    CMD_WPOS,
    CMD_TSTART,
    CMD_DIV_STEP,
    CMD_TEND,
    CMD_RMUL_LO,
    CMD_RMUL_HI,
    CMD_RSUM,
    CMD_RSTART,
    CMD_REND,
    CMD_WUPD,
    CMD_ADV,
    CMD_MSTART,
    CMD_MEND,
    CMD_OUT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] lane;
  } mwo_cmd_t;

  typedef struct packed {
    logic upd_ok;
    logic div_last;
    logic out_busy;
  } mwo_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WMUL,
    ST_WPOS,
    ST_TSTART,
    ST_TDIV,
    ST_TEND,
    ST_RMLO,
    ST_RMHI,
    ST_RSUM,
    ST_RSTART,
    ST_RDIV,
    ST_REND,
    ST_WUPD,
    ST_ADV,
    ST_MSTART,
    ST_MDIV,
    ST_MEND,
    ST_OUT
  } mwo_state_t;

endpackage

// ===== hdl/mwo_ctrl.sv =====
// Sequencer that steps the odometry datapath through one request.
module mwo_ctrl import mwo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mwo_stat_t stat,
  output mwo_cmd_t  cmd
);

  mwo_state_t state, state_next;
  logic [1:0] lane, lane_next;

  // Hold state and lane counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lane  <= 2'd0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
    end
  end

  // Choose next step and the datapath command
  always_comb begin
    state_next = state;
    lane_next  = lane;
    in_ready   = 1'b0;
    cmd.op     = CMD_IDLE;
    cmd.lane   = lane;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.op    = CMD_CHECK;
        lane_next = 2'd0;
        state_next = stat.upd_ok ? ST_WMUL : ST_OUT;
      end
      ST_WMUL: begin
        cmd.op     = CMD_WMUL;
        state_next = ST_WPOS;
      end
      ST_WPOS: begin
        cmd.op = CMD_WPOS;
        if (lane == 2'd3) begin
          lane_next  = 2'd0;
          state_next = ST_TSTART;
        end else begin
          lane_next  = lane + 2'd1;
          state_next = ST_WMUL;
        end
      end
      ST_TSTART: begin
        cmd.op     = CMD_TSTART;
        state_next = ST_TDIV;
      end
      ST_TDIV: begin
        cmd.op = CMD_DIV_STEP;
        if (stat.div_last) state_next = ST_TEND;
      end
      ST_TEND: begin
        cmd.op     = CMD_TEND;
        lane_next  = 2'd0;
        state_next = ST_RMLO;
      end
      ST_RMLO: begin
        cmd.op     = CMD_RMUL_LO;
        state_next = ST_RMHI;
      end
      ST_RMHI: begin
        cmd.op     = CMD_RMUL_HI;
        state_next = ST_RSUM;
      end
      ST_RSUM: begin
        cmd.op     = CMD_RSUM;
        state_next = ST_RSTART;
      end
      ST_RSTART: begin
        cmd.op     = CMD_RSTART;
        state_next = ST_RDIV;
      end
      ST_RDIV: begin
        cmd.op = CMD_DIV_STEP;
        if (stat.div_last) state_next = ST_REND;
      end
      ST_REND: begin
        cmd.op     = CMD_REND;
        state_next = ST_WUPD;
      end
      ST_WUPD: begin
        cmd.op = CMD_WUPD;
        if (lane == 2'd2) begin
          lane_next  = 2'd0;
          state_next = ST_ADV;
        end else begin
          lane_next  = lane + 2'd1;
          state_next = ST_RMLO;
        end
      end
      ST_ADV: begin
        cmd.op     = CMD_ADV;
        state_next = ST_MSTART;
      end
      ST_MSTART: begin
        cmd.op     = CMD_MSTART;
        state_next = ST_MDIV;
      end
      ST_MDIV: begin
        cmd.op = CMD_DIV_STEP;
        if (stat.div_last) state_next = ST_MEND;
      end
      ST_MEND: begin
        cmd.op = CMD_MEND;
        if (lane == 2'd2) begin
          lane_next  = 2'd0;
          state_next = ST_OUT;
        end else begin
          lane_next  = lane + 2'd1;
          state_next = ST_MSTART;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.op     = CMD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/mwo_dp.sv =====
// Odometry datapath: wheel multiplier, shared divider, window memory and state.
module mwo_dp import mwo_pkg::*; #(
  parameter int WINDOW_MAX      = 64,
  parameter int MIN_INTERVAL_US = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  mwo_in_t     in_data,
  input  mwo_cmd_t    cmd,
  output mwo_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output mwo_out_t    out_data
);

  localparam int HW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int AW   = $clog2(3 * WINDOW_MAX);
  localparam int WCAP = (WINDOW_MAX > 127) ? 127 : WINDOW_MAX;
  localparam logic [6:0] WCAP7 = 7'(WCAP);
  localparam int CW   = HW + 8;

  // Configuration
  logic [19:0] radius, wheel_base_k;
  logic [6:0]  window_size;

  // Odometry state
  logic signed [31:0] prev_pos [4];
  logic [39:0]        last_time;
  logic signed [47:0] pose [3];
  logic signed [39:0] sums [3];
  logic [6:0]         fill;
  logic [HW-1:0]      head;
  logic signed [31:0] mean [3];

  // Working registers
  mwo_in_t            in_reg;
  logic               acc;
  logic [39:0]        dt;
  logic signed [52:0] prod;
  logic signed [32:0] dwh [4];
  logic signed [48:0] disp [3];
  logic [44:0]        plo;
  logic [43:0]        phi;
  logic [67:0]        nprod;
  logic signed [31:0] sample;
  logic               rate_ovf;

  // Divider
  logic [67:0] div_d;
  logic [40:0] div_r;
  logic [39:0] div_den;
  logic [50:0] div_q;
  logic [5:0]  div_cnt;
  logic        div_neg;

  // Window memory
  logic [31:0]   win_mem [3*WINDOW_MAX];
  logic [31:0]   rdata;
  logic [AW-1:0] addr, lane_off;
  logic          we;

  // Combinational helpers
  logic signed [40:0] dt_full;
  logic [6:0]         win;
  logic [CW-1:0]      head_inc;
  logic [HW-1:0]      head_next;
  logic signed [31:0] angle_sel;
  logic signed [52:0] prod_next, prod_rnd;
  logic signed [36:0] pos37;
  logic signed [31:0] pos32;
  logic signed [32:0] d_new;
  logic signed [34:0] sum_fwd, sum_side, turn_num;
  logic [34:0]        turn_mag;
  logic signed [48:0] dsel;
  logic [48:0]        dmag;
  logic [32:0]        q33;
  logic signed [31:0] sample_next;
  logic signed [39:0] old_val;
  logic [39:0]        smag;
  logic [40:0]        rs;
  logic               ge;
  logic signed [49:0] pose_sum [3];
  logic signed [47:0] pose_next [3];

  always_comb begin
    // Interval since the last accepted update or init request
    dt_full     = $signed({1'b0, in_reg.time_us}) - $signed({1'b0, last_time});
    stat.upd_ok = (in_reg.req_type == REQ_UPDATE) &&
                  (dt_full >= $signed(41'(MIN_INTERVAL_US)));
    stat.div_last = (div_cnt == 6'd1);
    stat.out_busy = out_valid && !out_ready;

    // Effective window length and ring advance
    if (window_size == 7'd0)      win = 7'd1;
    else if (window_size > WCAP7) win = WCAP7;
    else                          win = window_size;
    head_inc  = CW'(head) + CW'(1);
    head_next = (head_inc >= CW'(win)) ? '0 : head_inc[HW-1:0];

    // Wheel angle to position
    unique case (cmd.lane)
      2'd0:    angle_sel = in_reg.front_left_angle;
      2'd1:    angle_sel = in_reg.front_right_angle;
      2'd2:    angle_sel = in_reg.back_left_angle;
      default: angle_sel = in_reg.back_right_angle;
    endcase
    prod_next = angle_sel * $signed({1'b0, radius});
    prod_rnd  = prod + 53'sd32768;
    pos37     = prod_rnd[52:16];
    if (pos37 > 37'sd2147483647)       pos32 = 32'sh7FFFFFFF;
    else if (pos37 < -37'sd2147483648) pos32 = 32'sh80000000;
    else                               pos32 = pos37[31:0];
    d_new = 33'(pos32) - 33'(prev_pos[cmd.lane]);

    // Body displacement terms
    sum_fwd  = 35'(dwh[0]) + 35'(dwh[1]) + 35'(dwh[2]) + 35'(dwh[3]) + 35'sd2;
    sum_side = 35'(dwh[0]) - 35'(dwh[1]) - 35'(dwh[2]) + 35'(dwh[3]) + 35'sd2;
    turn_num = 35'(dwh[1]) + 35'(dwh[3]) - 35'(dwh[0]) - 35'(dwh[2]);
    turn_mag = turn_num[34] ? 35'(-turn_num) : 35'(turn_num);

    // Displacement magnitude of the current lane
    dsel = disp[cmd.lane];
    dmag = dsel[48] ? 49'(-dsel) : 49'(dsel);

    // Saturate the velocity quotient
    q33 = div_q[32:0];
    if (!div_neg)
      sample_next = (rate_ovf || q33 > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : q33[31:0];
    else
      sample_next = (rate_ovf || q33 > 33'h080000000) ? 32'sh80000000 : -q33[31:0];

    // Oldest sample leaves once the window is full
    old_val = (fill >= win) ? 40'($signed(rdata)) : 40'sd0;
    smag    = sums[cmd.lane][39] ? 40'(-sums[cmd.lane]) : 40'(sums[cmd.lane]);

    // Restoring divider step
    rs = {div_r[39:0], div_d[67]};
    ge = (rs >= {1'b0, div_den});

    // Pose with saturation
    for (int i = 0; i < 3; i++) begin
      pose_sum[i] = 50'(pose[i]) + 50'(disp[i]);
      if (pose_sum[i] > 50'sh07FFFFFFFFFFF)       pose_next[i] = 48'sh7FFFFFFFFFFF;
      else if (pose_sum[i] < -50'sh0800000000000) pose_next[i] = 48'sh800000000000;
      else                                        pose_next[i] = pose_sum[i][47:0];
    end

    // Window memory address
    unique case (cmd.lane)
      2'd0:    lane_off = '0;
      2'd1:    lane_off = AW'(WINDOW_MAX);
      default: lane_off = AW'(2 * WINDOW_MAX);
    endcase
    addr = lane_off + AW'(head);
    we   = (cmd.op == CMD_WUPD);
  end

  // Store and read back velocity samples
  always_ff @(posedge clk) begin
    if (we) win_mem[addr] <= sample;
    rdata <= win_mem[addr];
  end

  // Control and odometry state
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= '0;
      wheel_base_k <= '0;
      window_size  <= 7'd1;
      for (int i = 0; i < 4; i++) prev_pos[i] <= '0;
      last_time <= '0;
      for (int i = 0; i < 3; i++) begin
        pose[i] <= '0;
        sums[i] <= '0;
        mean[i] <= '0;
      end
      fill      <= '0;
      head      <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result beat once taken, unless a new one is loaded
      if (out_valid && out_ready && cmd.op != CMD_OUT) out_valid <= 1'b0;

      unique case (cmd.op)
        CMD_LOAD: in_reg <= in_data;
        CMD_CHECK: begin
          acc <= stat.upd_ok;
          dt  <= dt_full[39:0];
          if (in_reg.req_type == REQ_INIT) begin
            for (int i = 0; i < 3; i++) sums[i] <= '0;
            fill      <= '0;
            head      <= '0;
            last_time <= in_reg.time_us;
          end
          if (in_reg.req_type == REQ_RESET_POSE)
            for (int i = 0; i < 3; i++) pose[i] <= '0;
        end
        CMD_WMUL: prod <= prod_next;
        CMD_WPOS: begin
          dwh[cmd.lane]      <= d_new;
          prev_pos[cmd.lane] <= pos32;
        end
        CMD_TSTART: begin
          disp[0] <= 49'($signed(sum_fwd[34:2]));
          disp[1] <= 49'($signed(sum_side[34:2]));
          div_d   <= {turn_mag, 33'd0};
          div_r   <= '0;
          div_q   <= '0;
          div_den <= 40'({wheel_base_k, 2'b00});
          div_cnt <= TURN_STEPS;
          div_neg <= turn_num[34];
        end
        CMD_DIV_STEP: begin
          if (div_cnt != 6'd0) begin
            div_r   <= ge ? rs - {1'b0, div_den} : rs;
            div_q   <= {div_q[49:0], ge};
            div_d   <= {div_d[66:0], 1'b0};
            div_cnt <= div_cnt - 6'd1;
          end
        end
        CMD_TEND: begin
          if (wheel_base_k == 20'd0) disp[2] <= '0;
          else if (div_neg)          disp[2] <= -$signed(div_q[48:0]);
          else                       disp[2] <= $signed(div_q[48:0]);
        end
        CMD_RMUL_LO: begin
          plo     <= 45'(dmag[24:0]) * 45'(ONE_MILLION);
          div_neg <= dsel[48];
        end
        CMD_RMUL_HI: phi <= 44'(dmag[48:25]) * 44'(ONE_MILLION);
        CMD_RSUM: nprod <= 68'(plo) + (68'(phi) << 25);
        CMD_RSTART: begin
          div_r    <= 41'(nprod[67:33]);
          div_d    <= {nprod[32:0], 35'd0};
          div_q    <= '0;
          div_den  <= dt;
          div_cnt  <= RATE_STEPS;
          rate_ovf <= (40'(nprod[67:33]) >= dt);
        end
        CMD_REND: sample <= sample_next;
        CMD_WUPD: sums[cmd.lane] <= sums[cmd.lane] - old_val + 40'(sample);
        CMD_ADV: begin
          for (int i = 0; i < 3; i++) pose[i] <= pose_next[i];
          head      <= head_next;
          if (fill < win) fill <= fill + 7'd1;
          last_time <= in_reg.time_us;
        end
        CMD_MSTART: begin
          div_d   <= {smag, 28'd0};
          div_r   <= '0;
          div_q   <= '0;
          div_den <= 40'(fill);
          div_cnt <= MEAN_STEPS;
          div_neg <= sums[cmd.lane][39];
        end
        CMD_MEND: mean[cmd.lane] <= div_neg ? -div_q[31:0] : div_q[31:0];
        CMD_OUT: begin
          out_valid             <= 1'b1;
          out_data.accepted     <= acc;
          out_data.pose_x       <= pose[0];
          out_data.pose_y       <= pose[1];
          out_data.pose_heading <= pose[2];
          out_data.vel_x        <= mean[0];
          out_data.vel_y        <= mean[1];
          out_data.vel_turn     <= mean[2];
        end
        default: ;
      endcase

      // Take register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_RADIUS:       radius       <= cfg_data;
          CFG_WHEEL_BASE_K: wheel_base_k <= cfg_data;
          CFG_WINDOW_SIZE: begin
            window_size <= cfg_data[6:0];
            for (int i = 0; i < 3; i++) sums[i] <= '0;
            fill <= '0;
            head <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/mecanum_wheel_odometry_unit.sv =====
// Update request: the sequence is dominated by the shared
//   bit-serial divider (51 steps for turn, 33 per velocity, 40 per mean).
// Init, reset-pose, unused and rejected requests go from the check straight to the output.
//   One request in flight; the result register lets the next one start while a beat waits.
// Reset (rst, synchronous): pose, wheel positions, time, windows and means clear;
//   window_size resets to 1. Window memory contents are not cleared.
module mecanum_wheel_odometry_unit import mwo_pkg::*; #(
  parameter int WINDOW_MAX      = 64,
  parameter int MIN_INTERVAL_US = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  mwo_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output mwo_out_t    out_data
);

  mwo_cmd_t  cmd;
  mwo_stat_t stat;

  // Register writes complete at once
  assign cfg_ready = 1'b1;

  mwo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mwo_dp #(
    .WINDOW_MAX      (WINDOW_MAX),
    .MIN_INTERVAL_US (MIN_INTERVAL_US)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_mecanum_wheel_odometry_unit.sv =====
// Testbench for the mecanum wheel odometry unit: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_mecanum_wheel_odometry_unit import mwo_pkg::*; ();

  localparam int WMAX = 64;
  localparam int MIN_DT = 100;

  // Odometry predictor and store of expected result beats
  class odo_scoreboard;
    longint unsigned radius, base_k, win_cfg;
    longint wheel_pos[4];
    longint unsigned stamp;
    longint pose[3];
    longint samples[3][WMAX];
    longint sums[3];
    int unsigned fill, head;
    longint means[3];
    mwo_out_t pending[$];
    int errors;

    function void clear_win();
      for (int i = 0; i < 3; i++) sums[i] = 0;
      fill = 0;
      head = 0;
    endfunction

    function void reset_state();
      radius = 0; base_k = 0; win_cfg = 1; stamp = 0;
      for (int i = 0; i < 4; i++) wheel_pos[i] = 0;
      for (int i = 0; i < 3; i++) begin
        pose[i] = 0;
        means[i] = 0;
      end
      clear_win();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      if (idx == CFG_RADIUS) radius = val;
      else if (idx == CFG_WHEEL_BASE_K) base_k = val;
      else if (idx == CFG_WINDOW_SIZE) begin
        win_cfg = val[6:0];
        clear_win();
      end
    endfunction

    function longint floor_shr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v - 1) >>> s) - 1;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Velocity sample: d * 1e6 / dt toward zero, saturated to 32 bits
    function longint velocity(longint d, longint unsigned dt);
      longint unsigned mag, q, r, m;
      mag = d < 0 ? longint'(-(d + 1)) + 1 : d;
      q = mag / dt;
      r = mag % dt;
      if (q >= 64'h1_0000_0000) m = 64'h1_0000_0000;
      else m = q * 1000000 + (r * 1000000) / dt;
      if (d < 0) return m > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(m);
      return m > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(m);
    endfunction

    function void note_request(mwo_in_t req);
      mwo_out_t res;
      longint dt, d[4], disp[3], a, p, s;
      int unsigned w;
      res = '0;
      if (req.req_type == REQ_UPDATE) begin
        dt = longint'(req.time_us) - longint'(stamp);
        if (dt >= MIN_DT) begin
          w = win_cfg == 0 ? 1 : (win_cfg > WMAX ? WMAX : win_cfg);
          a = 0;
          for (int i = 0; i < 4; i++) begin
            case (i)
              0: a = req.front_left_angle;
              1: a = req.front_right_angle;
              2: a = req.back_left_angle;
              default: a = req.back_right_angle;
            endcase
            p = sat(floor_shr(a * longint'(radius) + 32768, 16),
                    -64'sh8000_0000, 64'sh7FFF_FFFF);
            d[i] = p - wheel_pos[i];
            wheel_pos[i] = p;
          end
          disp[0] = floor_shr(d[0] + d[1] + d[2] + d[3] + 2, 2);
          disp[1] = floor_shr(d[0] - d[1] - d[2] + d[3] + 2, 2);
          if (base_k == 0) disp[2] = 0;
          else disp[2] = ((-d[0] + d[1] - d[2] + d[3]) * 65536) / longint'(4 * base_k);
          for (int i = 0; i < 3; i++) begin
            pose[i] = sat(pose[i] + disp[i], -64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF);
            s = velocity(disp[i], dt);
            if (fill >= w) sums[i] -= samples[i][head];
            samples[i][head] = s;
            sums[i] += s;
          end
          stamp = req.time_us;
          head = (head + 1 >= w) ? 0 : head + 1;
          if (fill < w) fill++;
          for (int i = 0; i < 3; i++) means[i] = sums[i] / longint'(fill);
          res.accepted = 1'b1;
        end
      end else if (req.req_type == REQ_INIT) begin
        clear_win();
        stamp = req.time_us;
      end else if (req.req_type == REQ_RESET_POSE) begin
        for (int i = 0; i < 3; i++) pose[i] = 0;
      end
      res.pose_x = pose[0];
      res.pose_y = pose[1];
      res.pose_heading = pose[2];
      res.vel_x = means[0];
      res.vel_y = means[1];
      res.vel_turn = means[2];
      pending.push_back(res);
    endfunction

    function void check_result(mwo_out_t got);
      mwo_out_t exp_res;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.accepted !== exp_res.accepted) begin
        $error("accepted: expected %0d, got %0d", exp_res.accepted, got.accepted);
        errors++;
      end
      if (got.pose_x !== exp_res.pose_x) begin
        $error("pose_x: expected %0d, got %0d", exp_res.pose_x, got.pose_x);
        errors++;
      end
      if (got.pose_y !== exp_res.pose_y) begin
        $error("pose_y: expected %0d, got %0d", exp_res.pose_y, got.pose_y);
        errors++;
      end
      if (got.pose_heading !== exp_res.pose_heading) begin
        $error("pose_heading: expected %0d, got %0d", exp_res.pose_heading,
               got.pose_heading);
        errors++;
      end
      if (got.vel_x !== exp_res.vel_x) begin
        $error("vel_x: expected %0d, got %0d", exp_res.vel_x, got.vel_x);
        errors++;
      end
      if (got.vel_y !== exp_res.vel_y) begin
        $error("vel_y: expected %0d, got %0d", exp_res.vel_y, got.vel_y);
        errors++;
      end
      if (got.vel_turn !== exp_res.vel_turn) begin
        $error("vel_turn: expected %0d, got %0d", exp_res.vel_turn, got.vel_turn);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mwo_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mwo_out_t    out_data;

  odo_scoreboard odo = new();
  bit idle_free = 1'b0;
  bit hold_off = 1'b0;
  longint unsigned clock_us = 0;
  longint angle_now[4];

  always #6 clk = ~clk;

  mecanum_wheel_odometry_unit #(.WINDOW_MAX(WMAX), .MIN_INTERVAL_US(MIN_DT)) i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  // Receive result beats with random stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) odo.check_result(out_data);
      out_ready <= !hold_off && (idle_free || $urandom_range(99) >= 16);
    end
  end

  // Long receiver hold-off, counted in its own process
  initial begin
    wait (clock_us > 300000);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic send_req(mwo_in_t req);
    while (!idle_free && $urandom_range(99) < 16) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    odo.note_request(req);
    // Drop valid after the beat
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    odo.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block drain before touching registers
  task automatic drain();
    while (odo.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_simple(logic [1:0] kind, longint unsigned t,
                             logic signed [31:0] a0, logic signed [31:0] a1,
                             logic signed [31:0] a2, logic signed [31:0] a3);
    mwo_in_t req;
    req.req_type = kind;
    req.front_left_angle = a0;
    req.front_right_angle = a1;
    req.back_left_angle = a2;
    req.back_right_angle = a3;
    req.time_us = t[39:0];
    send_req(req);
  endtask

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  // Update: time advances by a random interval, sometimes below the minimum; angles drift by a random step
  task automatic smooth_update();
    logic signed [31:0] a[4];
    int unsigned span;
    span = $urandom_range(3) == 0 ? 32'h7FFF_FFFF : 32'h0004_0000;
    for (int i = 0; i < 4; i++) begin
      angle_now[i] += longint'($urandom_range(2 * span)) - span;
      a[i] = 32'(angle_now[i]);
    end
    clock_us += $urandom_range(7) == 0 ? $urandom_range(120) : $urandom_range(100, 50000);
    send_simple(REQ_UPDATE, clock_us, a[0], a[1], a[2], a[3]);
  endtask

  task automatic noise_item();
    logic [39:0] t;
    t = 40'({$urandom(), $urandom()});
    if ($urandom_range(1)) clock_us = t;
    send_simple(2'($urandom_range(3)), t, rnd32(), rnd32(), rnd32(), rnd32());
  endtask

  task automatic random_phase(int count, int win, bit no_idle);
    drain();
    write_cfg(CFG_RADIUS, 20'($urandom_range(3) == 0 ? 20'hFFFFF : $urandom()));
    write_cfg(CFG_WHEEL_BASE_K, 20'($urandom_range(5) == 0 ? 20'd0 : $urandom()));
    write_cfg(CFG_WINDOW_SIZE, 20'(win));
    idle_free = no_idle || ($urandom_range(3) == 0);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(19))
        0: send_simple(REQ_INIT, clock_us, rnd32(), rnd32(), rnd32(), rnd32());
        1: send_simple(REQ_RESET_POSE, clock_us, rnd32(), rnd32(), rnd32(), rnd32());
        2, 3: noise_item();
        default: smooth_update();
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) angle_now[i] = 0;
    odo.reset_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every request type, short and backward intervals
    write_cfg(CFG_RADIUS, 20'hFFFFF);
    write_cfg(CFG_WHEEL_BASE_K, 20'd0);
    write_cfg(CFG_WINDOW_SIZE, 20'd4);
    send_simple(REQ_UPDATE, 40'd99, 32'h7FFF_FFFF, 0, 0, 0);
    send_simple(REQ_UPDATE, 40'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000);
    send_simple(REQ_UPDATE, 40'd200, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF);
    send_simple(REQ_UPDATE, 40'd150, 1, 1, 1, 1);
    send_simple(REQ_UPDATE, 40'hFF_FFFF_FFFF, -1, -1, -1, -1);
    send_simple(REQ_UPDATE, 40'd300, 0, 0, 0, 0);
    send_simple(REQ_INIT, 40'd0, 0, 0, 0, 0);
    send_simple(REQ_UPDATE, 40'd100, 32'h0001_0000, 0, 0, 0);
    send_simple(REQ_RESET_POSE, 40'd0, 0, 0, 0, 0);
    send_simple(2'd3, 40'hFF_FFFF_FFFF, -1, -1, -1, -1);
    drain();
    write_cfg(CFG_WHEEL_BASE_K, 20'd1);
    write_cfg(CFG_WINDOW_SIZE, 20'd0);
    send_simple(REQ_INIT, 40'd1000, 0, 0, 0, 0);
    send_simple(REQ_UPDATE, 40'd1100, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF);
    send_simple(REQ_UPDATE, 40'd1200, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000);
    drain();
    write_cfg(CFG_WINDOW_SIZE, 20'd127);
    write_cfg(2'd3, 20'hABCDE);
    write_cfg(CFG_WHEEL_BASE_K, 20'hFFFFF);
    send_simple(REQ_INIT, 40'd5000, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++)
      send_simple(REQ_UPDATE, 40'd5200 + 40'(i * 100), i * 32'h0003_0000, -i, i, 0);
    clock_us = 6000;
    send_simple(REQ_INIT, clock_us, 0, 0, 0, 0);

    // Random phases over a spread of window sizes, one with no idling
    random_phase(300, 1, 1'b0);
    random_phase(300, 64, 1'b1);
    random_phase(300, 5, 1'b0);
    random_phase(300, 0, 1'b0);
    random_phase(275, 100, 1'b0);
    random_phase(250, $urandom_range(2, 63), 1'b0);

    drain();
    repeat (400) @(posedge clk);
    if (odo.errors == 0 && odo.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
